// ===== design/crmc_pkg.sv =====
`timescale 1ns / 1ps

package crmc_pkg;

    // Field and datapath widths
    localparam int BOUND_WIDTH  = 20;
    localparam int WORK_WIDTH   = 64;
    localparam int LENGTH_WIDTH = 10;

    // Saturated cycle length
    localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = {LENGTH_WIDTH{1'b1}};

    // Largest work value whose 3n+1 still fits in WORK_WIDTH bits
    localparam logic [WORK_WIDTH-1:0] WORK_MASK    = {WORK_WIDTH{1'b1}};
    localparam logic [WORK_WIDTH-1:0] TRIPLE_LIMIT = (WORK_MASK - WORK_WIDTH'(1)) / 3;

endpackage

// ===== design/crmc_req_if.sv =====
`timescale 1ns / 1ps

interface crmc_req_if;
    import crmc_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [BOUND_WIDTH-1:0] bound_a;
    logic [BOUND_WIDTH-1:0] bound_b;

    modport source (output valid, output bound_a, output bound_b, input ready);
    modport sink   (input valid, input bound_a, input bound_b, output ready);

endinterface

// ===== design/crmc_rsp_if.sv =====
`timescale 1ns / 1ps

interface crmc_rsp_if;
    import crmc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [LENGTH_WIDTH-1:0] max_length;
    logic                    limit_hit;

    modport source (output valid, output max_length, output limit_hit, input ready);
    modport sink   (input valid, input max_length, input limit_hit, output ready);

endinterface

// ===== design/collatz_range_max_cycle_core.sv =====
`timescale 1ns / 1ps

// Collatz range maximum cycle length.
// req carries two range bounds in either order; rsp returns one transaction per
// request with the largest 3n+1 cycle length over the inclusive range and a flag
// that is set when any walk saturated (length limit or work overflow).
// A start value of zero has length 0.
// The block works on one request at a time: req.ready is high only while the
// sequencer is idle. One shared step unit (shift, or 3n+1 with overflow check)
// advances the walk by one value per cycle. A walk of length L takes L-1 steps
// and is then folded into the running maximum; a zero start takes no steps.
// The result sits in an output register, so a new request is accepted while the
// previous result still waits; if rsp is stalled when the next result is done,
// the sequencer holds it until the output register frees up.
// Reset clears the sequencer and drops any pending result.
module collatz_range_max_cycle_core
(
    input  logic       clk,
    input  logic       rst_n,
    crmc_req_if.sink   req,
    crmc_rsp_if.source rsp
);
    import crmc_pkg::*;

    typedef enum logic [2:0]
    {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                  state_reg,    state_next;
    logic [BOUND_WIDTH-1:0]  cur_reg,      cur_next;
    logic [BOUND_WIDTH-1:0]  hi_reg,       hi_next;
    logic [WORK_WIDTH-1:0]   work_reg,     work_next;
    logic [LENGTH_WIDTH-1:0] step_reg,     step_next;
    logic [LENGTH_WIDTH-1:0] best_reg,     best_next;
    logic                    sat_reg,      sat_next;
    logic                    out_valid_reg, out_valid_next;
    logic [LENGTH_WIDTH-1:0] out_len_reg,  out_len_next;
    logic                    out_hit_reg,  out_hit_next;

    logic [BOUND_WIDTH-1:0]  lo_bound;
    logic [BOUND_WIDTH-1:0]  hi_bound;
    logic [BOUND_WIDTH-1:0]  cur_inc;
    logic [WORK_WIDTH-1:0]   triple_sum;
    logic                    walk_end;
    logic                    walk_sat;
    logic [LENGTH_WIDTH-1:0] walk_len;
    logic                    out_free;

    // Order the bounds
    assign lo_bound = (req.bound_a < req.bound_b) ? req.bound_a : req.bound_b;
    assign hi_bound = (req.bound_a < req.bound_b) ? req.bound_b : req.bound_a;

    // Shared step unit
    assign cur_inc    = cur_reg + BOUND_WIDTH'(1);
    assign triple_sum = (work_reg << 1) + work_reg + WORK_WIDTH'(1);

    // Walk termination: reached one (or zero start), length limit, or overflow
    always_comb
    begin
        walk_end = 1'b0;
        walk_sat = 1'b0;
        if (work_reg == WORK_WIDTH'(0) || work_reg == WORK_WIDTH'(1))
        begin
            walk_end = 1'b1;
        end
        else if (step_reg == LEN_MAX)
        begin
            walk_end = 1'b1;
            walk_sat = 1'b1;
        end
        else if (work_reg[0] && work_reg > TRIPLE_LIMIT)
        begin
            walk_end = 1'b1;
            walk_sat = 1'b1;
        end
    end

    assign walk_len = walk_sat ? LEN_MAX : step_reg;
    assign out_free = !out_valid_reg || rsp.ready;

    // Sequencer and datapath
    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        hi_next        = hi_reg;
        work_next      = work_reg;
        step_next      = step_reg;
        best_next      = best_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg;
        out_len_next   = out_len_reg;
        out_hit_next   = out_hit_reg;

        // Drop the result once the transaction completes
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    cur_next   = lo_bound;
                    hi_next    = hi_bound;
                    work_next  = {{(WORK_WIDTH-BOUND_WIDTH){1'b0}}, lo_bound};
                    step_next  = (lo_bound == BOUND_WIDTH'(0)) ? LENGTH_WIDTH'(0)
                                                               : LENGTH_WIDTH'(1);
                    best_next  = LENGTH_WIDTH'(0);
                    sat_next   = 1'b0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (walk_end)
                begin
                    // Fold the walk into the running maximum
                    if (walk_len > best_reg)
                    begin
                        best_next = walk_len;
                    end
                    if (walk_sat)
                    begin
                        sat_next = 1'b1;
                    end
                    if (cur_reg == hi_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        // Advance to the next start value, never zero here
                        cur_next  = cur_inc;
                        work_next = {{(WORK_WIDTH-BOUND_WIDTH){1'b0}}, cur_inc};
                        step_next = LENGTH_WIDTH'(1);
                    end
                end
                else
                begin
                    work_next = work_reg[0] ? triple_sum : (work_reg >> 1);
                    step_next = step_reg + LENGTH_WIDTH'(1);
                end
            end
            ST_DONE:
            begin
                // Hold the result until the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_len_next   = best_reg;
                    out_hit_next   = sat_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_reg       <= '0;
            hi_reg        <= '0;
            work_reg      <= '0;
            step_reg      <= '0;
            best_reg      <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_len_reg   <= '0;
            out_hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            hi_reg        <= hi_next;
            work_reg      <= work_next;
            step_reg      <= step_next;
            best_reg      <= best_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
            out_len_reg   <= out_len_next;
            out_hit_reg   <= out_hit_next;
        end
    end

    // Drive the channels
    assign req.ready      = (state_reg == ST_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.max_length = out_len_reg;
    assign rsp.limit_hit  = out_hit_reg;

    // A saturated walk forces the reported maximum to the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_hit_reg |-> out_len_reg == LEN_MAX)
    else $error("limit_hit set without saturated max_length");

    // The walk never runs past the upper bound
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> cur_reg <= hi_reg)
    else $error("start value beyond upper bound");

    // A zero work value only comes from a zero start with zero length
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK && work_reg == WORK_WIDTH'(0)
            |-> cur_reg == BOUND_WIDTH'(0) && step_reg == LENGTH_WIDTH'(0))
    else $error("zero work value on a nonzero start");

    // An accepted request starts a walk
    assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> state_reg == ST_WALK && best_reg == LENGTH_WIDTH'(0))
    else $error("request accepted without starting a walk");

    // A newly shown result carries the finished maximum
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> out_len_reg == $past(best_reg))
    else $error("result does not match running maximum");

endmodule
